// File: rtl/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared types and character codes for the log record parser and decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lrp_pkg;

  // Character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  // Result kinds
  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  decoded_char;
    logic [31:0] stamp;
    logic [15:0] query_length;
    logic        record_ok;
    logic        last_of_run;
  } out_t;

  // Everything one input byte produces: a decoded char, a record, or both
  typedef struct packed {
    logic        char_vld;
    logic [7:0]  char_val;
    logic        rec_vld;
    logic [31:0] stamp;
    logic [15:0] query_length;
    logic        record_ok;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/log_record_parse_url_decode.sv
// ----------------------------------------------------------------------------
// log_record_parse_url_decode
// Log line parser with on-the-fly percent decoding of the query part.
// ----------------------------------------------------------------------------
//
//  channel | signals                         | word
//  --------+---------------------------------+------------------------------
//  in      | in_valid_i / in_ready_o         | in_t: byte_in, end_of_stream
//  out     | out_valid_o / out_ready_i       | out_t: char or record summary
//
//  One input byte is taken per cycle while the queue is not full. Each byte
//  yields zero, one or two output words; the output side sends one word per
//  cycle while out_ready_i is high; a byte giving both a char and a record
//  sends the char word, then the record word. Front (line state update) and
//  back (word sequencer) are parted by a two-entry queue: in_ready_o drops
//  only while that queue is full.
//  Reset (asynchronous, active low) clears the line state and empties the
//  queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module log_record_parse_url_decode #(
  parameter int unsigned STAMP_BITS  = 32,  // timestamp accumulator, 16..64
  parameter int unsigned LENGTH_BITS = 16   // query length counter, 8..32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lrp_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output lrp_pkg::out_t       out_data_o
);
  import lrp_pkg::*;

  logic   q_full, q_valid, q_pop, push;
  entry_t push_entry, head_entry;

  // front only waits on queue space, never on the output side
  assign in_ready_o = !q_full;

  lrp_front #(
    .STAMP_BITS  (STAMP_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_valid_i && in_ready_o),
    .data_i   (in_data_i),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  lrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .pop_i   (q_pop)
  );

  lrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: rtl/lrp_front.sv
// ----------------------------------------------------------------------------
// lrp_front
// Line state machine: timestamp, separators, percent-decoded query.
// ----------------------------------------------------------------------------
`default_nettype none

module lrp_front #(
  parameter int unsigned STAMP_BITS  = 32,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire lrp_pkg::in_t   data_i,
  output logic                push_o,
  output lrp_pkg::entry_t     entry_o
);
  import lrp_pkg::*;

  typedef enum logic [1:0] {
    PH_STAMP,
    PH_SEP,
    PH_QUERY
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [STAMP_BITS-1:0]  stamp_q, stamp_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [1:0]             esc_q, esc_d;
  logic [7:0]             hex_q, hex_d;
  logic                   bad_q, bad_d;
  logic                   started_q, started_d;

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c inside {[CH_0:CH_9]}) begin
      t = c - CH_0;
      return {1'b1, t[3:0]};
    end else if (c inside {[CH_UA:CH_UF]}) begin
      t = c - CH_UA + 8'd10;
      return {1'b1, t[3:0]};
    end else if (c inside {[CH_LA:CH_LF_HEX]}) begin
      t = c - CH_LA + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'b0;
  endfunction

  always_comb begin
    logic [7:0]              c;
    logic                    eos;
    logic [STAMP_BITS+3:0]   prod;
    logic [7:0]              dig;
    logic [4:0]              hv;
    logic [STAMP_BITS+31:0]  stamp_w;
    logic [LENGTH_BITS+15:0] len_w;

    c        = data_i.byte_in;
    eos      = data_i.end_of_stream;
    dig      = c - CH_0;
    prod     = {1'b0, stamp_q, 3'b000} + {3'b000, stamp_q, 1'b0}
             + {{STAMP_BITS{1'b0}}, dig[3:0]};
    hv       = hex_val(c);
    stamp_w  = '0;
    len_w    = '0;

    phase_d   = phase_q;
    stamp_d   = stamp_q;
    len_d     = len_q;
    esc_d     = esc_q;
    hex_d     = hex_q;
    bad_d     = bad_q;
    started_d = started_q;
    push_o    = 1'b0;
    entry_o   = '0;

    if (accept_i) begin
      if (c == CH_LF) begin
        if (!(eos && !started_q)) begin
          entry_o.rec_vld = 1'b1;
        end
      end else begin
        started_d = 1'b1;
        case (phase_q)
          PH_STAMP: begin
            if (c inside {[CH_0:CH_9]}) begin
              // x*10 + d, saturating
              if (prod[STAMP_BITS+3:STAMP_BITS] != 4'd0) begin
                stamp_d = '1;
              end else begin
                stamp_d = prod[STAMP_BITS-1:0];
              end
            end else if (c == CH_SPACE || c == CH_TAB) begin
              phase_d = PH_SEP;
            end else begin
              phase_d = PH_QUERY;
            end
          end
          PH_SEP: begin
            if (!(c == CH_SPACE || c == CH_TAB)) begin
              phase_d = PH_QUERY;
            end
          end
          default: begin
            phase_d = PH_QUERY;
          end
        endcase

        if (phase_d == PH_QUERY) begin
          if (len_q != '1) begin
            len_d = len_q + 1'b1;
          end
          if (c == CH_PLUS) begin
            entry_o.char_vld = 1'b1;
            entry_o.char_val = CH_SPACE;
          end else if (c == CH_PCT) begin
            // (re)open escape
            esc_d = 2'd2;
            hex_d = 8'h00;
            bad_d = 1'b0;
          end else if (esc_q == 2'd0) begin
            entry_o.char_vld = 1'b1;
            entry_o.char_val = c;
          end else begin
            if (hv[4] && !bad_q) begin
              hex_d = {hex_q[3:0], hv[3:0]};
            end else begin
              bad_d = 1'b1;
            end
            esc_d = esc_q - 2'd1;
            if (esc_d == 2'd0 && !bad_d && hex_d != 8'h00) begin
              entry_o.char_vld = 1'b1;
              entry_o.char_val = hex_d;
            end
          end
        end

        if (eos) begin
          entry_o.rec_vld = 1'b1;
        end
      end

      // record fields from the updated line state, masked to port widths
      stamp_w              = {32'b0, stamp_d};
      len_w                = {16'b0, len_d};
      entry_o.stamp        = stamp_w[31:0];
      entry_o.query_length = len_w[15:0];
      entry_o.record_ok    = (stamp_d != '0) && (len_d != '0);
      if (!entry_o.rec_vld) begin
        entry_o.stamp        = '0;
        entry_o.query_length = '0;
        entry_o.record_ok    = 1'b0;
      end
      push_o = entry_o.char_vld || entry_o.rec_vld;

      // line end clears all line state
      if (c == CH_LF || eos) begin
        phase_d   = PH_STAMP;
        stamp_d   = '0;
        len_d     = '0;
        esc_d     = 2'd0;
        hex_d     = 8'h00;
        bad_d     = 1'b0;
        started_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_STAMP;
      stamp_q   <= '0;
      len_q     <= '0;
      esc_q     <= 2'd0;
      hex_q     <= 8'h00;
      bad_q     <= 1'b0;
      started_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      stamp_q   <= stamp_d;
      len_q     <= len_d;
      esc_q     <= esc_d;
      hex_q     <= hex_d;
      bad_q     <= bad_d;
      started_q <= started_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lrp_queue.sv
// ----------------------------------------------------------------------------
// lrp_queue
// Short entry queue between the line parser and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lrp_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lrp_pkg::entry_t   entry_i,
  output logic                   full_o,
  output logic                   valid_o,
  output lrp_pkg::entry_t        entry_o,
  input  wire logic              pop_i
);
  import lrp_pkg::*;

  localparam int unsigned PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  entry_t          slot_q [QDEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");

endmodule

`default_nettype wire

// File: rtl/lrp_back.sv
// ----------------------------------------------------------------------------
// lrp_back
// Output sequencer: splits each entry into char and record words.
// ----------------------------------------------------------------------------
`default_nettype none

module lrp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire lrp_pkg::entry_t   q_entry_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output lrp_pkg::out_t          out_data_o
);
  import lrp_pkg::*;

  entry_t cur_q;
  logic   pend_char_q, pend_rec_q;
  logic   busy, last_word, take;

  assign busy      = pend_char_q || pend_rec_q;
  assign last_word = !(pend_char_q && pend_rec_q);
  // take a new entry when idle or when the last word leaves this cycle
  assign take      = !busy || (out_ready_i && last_word);
  assign q_pop_o   = take && q_valid_i;

  always_comb begin
    out_data_o             = '0;
    out_data_o.last_of_run = last_word;
    if (pend_char_q) begin
      out_data_o.kind         = KIND_CHAR;
      out_data_o.decoded_char = cur_q.char_val;
    end else begin
      out_data_o.kind         = KIND_RECORD;
      out_data_o.stamp        = cur_q.stamp;
      out_data_o.query_length = cur_q.query_length;
      out_data_o.record_ok    = cur_q.record_ok;
    end
  end
  assign out_valid_o = busy;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_char_q <= 1'b0;
      pend_rec_q  <= 1'b0;
    end else if (take) begin
      pend_char_q <= q_valid_i && q_entry_i.char_vld;
      pend_rec_q  <= q_valid_i && q_entry_i.rec_vld;
    end else if (out_ready_i) begin
      pend_char_q <= 1'b0;
    end
  end

  a_pop_when_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop without a queued entry");

  a_char_then_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.kind == KIND_CHAR
     && !out_data_o.last_of_run)
    |=> (out_valid_o && out_data_o.kind == KIND_RECORD && out_data_o.last_of_run))
    else $error("record word did not follow its char word");

endmodule

`default_nettype wire
